FILE: rtl/core/lsbsq_pkg.sv
// ----------------------------------------------------------------------------
// lsbsq_pkg
// Shared types, codes and reset values of the lsb-first spi register sequencer.
// ----------------------------------------------------------------------------
package lsbsq_pkg;

	localparam int DELAY_BITS_DEF  = 24;
	localparam int QUEUE_DEPTH_DEF = 2;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;

	localparam logic [CFG_IDX_W-1:0] CFG_SCK_HALF   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SEL_SETUP  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MODE_DELAY = 2'd2;

	localparam logic [15:0] SCK_HALF_RST   = 16'd1;
	localparam logic [15:0] SEL_SETUP_RST  = 16'd2;
	localparam logic [23:0] MODE_DELAY_RST = 24'd50000;

	localparam logic [7:0] DUMMY_BYTE = 8'hFF;

	typedef enum logic [2:0] {
		OP_READ        = 3'd0,
		OP_WRITE       = 3'd1,
		OP_ENTER_FLASH = 3'd2,
		OP_LEAVE_FLASH = 3'd3,
		OP_FORCE_LEAVE = 3'd4,
		OP_SHUTDOWN    = 3'd5
	} op_t;

	// raw input word
	typedef struct packed {
		logic        start_req;
		logic [2:0]  op;
		logic [5:0]  reg_req;
		logic [2:0]  byte_count;
		logic [31:0] wdata;
		logic        miso;
	} req_t;

	// result word
	typedef struct packed {
		logic        select_n;
		logic        sck;
		logic        mosi;
		logic        eject_line;
		logic        xx_line;
		logic        busy_res;
		logic        done_res;
		logic [31:0] rdata;
		logic        flash_mode;
	} rsp_t;

	// classified tick, as queued between front and engine
	typedef struct packed {
		logic        start;
		op_t         op;
		logic [5:0]  reg_req;
		logic [2:0]  count;
		logic [31:0] wdata;
		logic        miso;
	} tick_t;

endpackage

FILE: rtl/core/lsb_spi_register_access_sequencer_unit.sv
// ----------------------------------------------------------------------------
// lsb_spi_register_access_sequencer_unit
// Tick-driven lsb-first spi master for register reads, writes and
// flash-mode pin sequences.
// ----------------------------------------------------------------------------
// Each input word is one tick of the serial link and yields exactly one
// result word holding the pin levels, busy/done flags, read data and
// flash-mode flag after that tick. The engine steps one tick per clock while
// a word is queued and the result queue has room, so the block then sustains
// one word per cycle; a word is registered in the input queue and then in the
// result queue. Input and result queues of QUEUE_DEPTH entries let either side
// stall, until they fill, without stopping the other. Configuration writes
// take effect on the next clock and are meant for an idle block.
// ----------------------------------------------------------------------------
module lsb_spi_register_access_sequencer_unit import lsbsq_pkg::*; #(
	parameter int DELAY_BITS  = DELAY_BITS_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  push,
	output logic                  full,
	input  req_t                  req,
	output logic                  empty,
	input  logic                  pop,
	output rsp_t                  rsp
);

	tick_t item;
	logic  item_empty, item_pop;

	lsbsq_front #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.req    (req),
		.item   (item),
		.empty  (item_empty),
		.pop    (item_pop)
	);

	lsbsq_engine #(
		.DELAY_BITS  (DELAY_BITS),
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.item      (item),
		.in_empty  (item_empty),
		.in_pop    (item_pop),
		.rsp       (rsp),
		.empty     (empty),
		.pop       (pop)
	);

endmodule

FILE: rtl/core/lsbsq_queue.sv
// ----------------------------------------------------------------------------
// lsbsq_queue
// Small first-in first-out queue of register slots with full and empty flags.
// ----------------------------------------------------------------------------
module lsbsq_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_data = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: rtl/core/lsbsq_front.sv
// ----------------------------------------------------------------------------
// lsbsq_front
// Takes input words, screens the opcode, clamps the read count and queues
// the classified ticks for the engine.
// ----------------------------------------------------------------------------
module lsbsq_front import lsbsq_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	output logic  full,
	input  req_t  req,
	output tick_t item,
	output logic  empty,
	input  logic  pop
);

	tick_t                   cls;
	logic [$bits(tick_t)-1:0] rd_vec;

	always_comb begin
		cls.start   = req.start_req && (req.op <= 3'd5);
		cls.op      = op_t'(req.op);
		cls.reg_req = req.reg_req;
		cls.wdata   = req.wdata;
		cls.miso    = req.miso;
		// zero fetches one byte, anything above four fetches four
		if (req.byte_count == 3'd0) begin
			cls.count = 3'd1;
		end else if (req.byte_count > 3'd4) begin
			cls.count = 3'd4;
		end else begin
			cls.count = req.byte_count;
		end
	end

	lsbsq_queue #(
		.WIDTH ($bits(tick_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_in_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_data (cls),
		.full    (full),
		.pop     (pop),
		.rd_data (rd_vec),
		.empty   (empty)
	);

	assign item = tick_t'(rd_vec);

endmodule

FILE: rtl/core/lsbsq_engine.sv
// ----------------------------------------------------------------------------
// lsbsq_engine
// Pin sequencer: steps queued ticks through the spi byte and mode pin
// sequences, one per cycle while the result queue has room; queues their pins.
// ----------------------------------------------------------------------------
module lsbsq_engine import lsbsq_pkg::*; #(
	parameter int DELAY_BITS  = DELAY_BITS_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  tick_t                 item,
	input  logic                  in_empty,
	output logic                  in_pop,
	output rsp_t                  rsp,
	output logic                  empty,
	input  logic                  pop
);

	typedef enum logic [8:0] {
		PH_IDLE    = 9'b000000001,
		PH_SEL     = 9'b000000010,
		PH_LOW     = 9'b000000100,
		PH_HIGH    = 9'b000001000,
		PH_SHUT_W  = 9'b000010000,
		PH_ENT_W1  = 9'b000100000,
		PH_ENT_W2  = 9'b001000000,
		PH_ENT_W3  = 9'b010000000,
		PH_LEAVE_W = 9'b100000000
	} phase_t;

	// configuration
	logic [15:0] sck_half_q, sel_setup_q;
	logic [23:0] mode_delay_q;

	// sequencer state
	phase_t                phase_q, n_phase;
	logic [DELAY_BITS-1:0] cnt_q, n_cnt;
	logic [2:0]            bit_q, n_bit, byte_q, n_byte;
	logic [7:0]            shift_q, n_shift;
	logic [31:0]           read_q, n_read;
	logic                  flash_q, n_flash;
	logic                  ss_q, sck_q, mosi_q, ej_q, xx_q;
	logic                  n_ss, n_sck, n_mosi, n_ej, n_xx;
	op_t                   cmd_op_q, n_cmd_op;
	logic [5:0]            cmd_reg_q, n_cmd_reg;
	logic [2:0]            cmd_count_q, n_cmd_count;
	logic [31:0]           cmd_wdata_q, n_cmd_wdata;

	logic                  done, do_start, out_full, advance;
	logic [DELAY_BITS-1:0] half_hold, mode_wait, sel_wait;
	logic [2:0]            total, byte_inc, byte_m2;
	logic [4:0]            rd_pos;
	rsp_t                  nxt_rsp;
	logic [$bits(rsp_t)-1:0] rd_vec;

	function automatic logic fetch_f(input op_t op, input logic [2:0] b);
		return (op == OP_READ) && (b >= 3'd2);
	endfunction

	function automatic logic [7:0] load_f(input op_t op, input logic [5:0] rg,
			input logic [31:0] wd, input logic [2:0] idx);
		logic [2:0] sel;
		sel = idx - 3'd1;
		if (idx == 3'd0) begin
			return {rg, (op == OP_READ) ? 2'b01 : 2'b10};
		end else if (op == OP_READ) begin
			return (idx == 3'd1) ? DUMMY_BYTE : 8'h00;
		end else begin
			case (sel[1:0])
				2'd0:    return wd[7:0];
				2'd1:    return wd[15:8];
				2'd2:    return wd[23:16];
				default: return wd[31:24];
			endcase
		end
	endfunction

	assign advance   = !in_empty && !out_full;
	assign in_pop    = advance;
	assign half_hold = (sck_half_q == 16'd0) ? '0 : DELAY_BITS'(sck_half_q - 16'd1);
	assign mode_wait = DELAY_BITS'(mode_delay_q);
	assign sel_wait  = DELAY_BITS'(sel_setup_q);
	assign total     = (cmd_op_q == OP_READ) ? 3'd2 + cmd_count_q : 3'd5;
	assign byte_inc  = byte_q + 3'd1;
	assign byte_m2   = byte_q - 3'd2;
	assign rd_pos    = {byte_m2[1:0], bit_q};

	always_comb begin
		n_phase     = phase_q;
		n_cnt       = cnt_q;
		n_bit       = bit_q;
		n_byte      = byte_q;
		n_shift     = shift_q;
		n_read      = read_q;
		n_flash     = flash_q;
		n_ss        = ss_q;
		n_sck       = sck_q;
		n_mosi      = mosi_q;
		n_ej        = ej_q;
		n_xx        = xx_q;
		n_cmd_op    = cmd_op_q;
		n_cmd_reg   = cmd_reg_q;
		n_cmd_count = cmd_count_q;
		n_cmd_wdata = cmd_wdata_q;
		done        = 1'b0;
		do_start    = 1'b0;

		if (phase_q == PH_IDLE) begin
			if (item.start) begin
				n_cmd_op    = item.op;
				n_cmd_reg   = item.reg_req;
				n_cmd_count = item.count;
				n_cmd_wdata = item.wdata;
				case (item.op)
					OP_READ, OP_WRITE: begin
						if (item.op == OP_READ) begin
							n_read = '0;
						end
						n_ss    = 1'b0;
						n_cnt   = sel_wait;
						n_phase = PH_SEL;
					end
					OP_ENTER_FLASH: begin
						n_xx    = 1'b0;
						n_cnt   = mode_wait;
						n_phase = PH_ENT_W1;
					end
					OP_SHUTDOWN: begin
						n_ss    = 1'b1;
						n_xx    = 1'b0;
						n_ej    = 1'b0;
						n_cnt   = mode_wait;
						n_phase = PH_SHUT_W;
					end
					default: begin
						// a plain leave outside flash mode only reports done
						if (flash_q || item.op == OP_FORCE_LEAVE) begin
							n_ss    = 1'b1;
							n_ej    = 1'b0;
							n_cnt   = mode_wait;
							n_phase = PH_LEAVE_W;
						end else begin
							done = 1'b1;
						end
					end
				endcase
			end
		end else if (cnt_q != '0) begin
			n_cnt = cnt_q - 1'b1;
		end else begin
			case (phase_q)
				PH_SEL: begin
					n_byte   = 3'd0;
					n_bit    = 3'd0;
					n_shift  = load_f(cmd_op_q, cmd_reg_q, cmd_wdata_q, 3'd0);
					do_start = 1'b1;
				end
				PH_LOW: begin
					n_sck   = 1'b1;
					n_cnt   = half_hold;
					n_phase = PH_HIGH;
				end
				PH_HIGH: begin
					// miso is sampled on the tick that ends the high level
					if (fetch_f(cmd_op_q, byte_q)) begin
						n_read[rd_pos] = read_q[rd_pos] | item.miso;
					end
					n_sck = 1'b0;
					if (bit_q < 3'd7) begin
						n_bit    = bit_q + 3'd1;
						do_start = 1'b1;
					end else begin
						n_byte = byte_inc;
						if (byte_inc < total) begin
							n_bit    = 3'd0;
							n_shift  = load_f(cmd_op_q, cmd_reg_q, cmd_wdata_q, byte_inc);
							do_start = 1'b1;
						end else begin
							n_ss    = 1'b1;
							done    = 1'b1;
							n_phase = PH_IDLE;
						end
					end
				end
				PH_SHUT_W: begin
					n_ej    = 1'b1;
					done    = 1'b1;
					n_phase = PH_IDLE;
				end
				PH_ENT_W1: begin
					n_ss    = 1'b0;
					n_ej    = 1'b0;
					n_cnt   = mode_wait;
					n_phase = PH_ENT_W2;
				end
				PH_ENT_W2: begin
					n_xx    = 1'b1;
					n_ej    = 1'b1;
					n_cnt   = mode_wait;
					n_phase = PH_ENT_W3;
				end
				PH_ENT_W3: begin
					n_ss    = 1'b0;
					n_flash = 1'b1;
					done    = 1'b1;
					n_phase = PH_IDLE;
				end
				PH_LEAVE_W: begin
					n_xx    = 1'b0;
					n_ej    = 1'b1;
					n_flash = 1'b0;
					done    = 1'b1;
					n_phase = PH_IDLE;
				end
				default: begin
					n_phase = PH_IDLE;
				end
			endcase
		end

		// drive the next bit with sck low; mosi idles low while fetching
		if (do_start) begin
			n_mosi  = fetch_f(cmd_op_q, n_byte) ? 1'b0 : n_shift[n_bit];
			n_sck   = 1'b0;
			n_cnt   = half_hold;
			n_phase = PH_LOW;
		end
	end

	always_comb begin
		nxt_rsp.select_n   = n_ss;
		nxt_rsp.sck        = n_sck;
		nxt_rsp.mosi       = n_mosi;
		nxt_rsp.eject_line = n_ej;
		nxt_rsp.xx_line    = n_xx;
		nxt_rsp.busy_res   = (n_phase != PH_IDLE);
		nxt_rsp.done_res   = done;
		nxt_rsp.rdata      = n_read;
		nxt_rsp.flash_mode = n_flash;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sck_half_q   <= SCK_HALF_RST;
			sel_setup_q  <= SEL_SETUP_RST;
			mode_delay_q <= MODE_DELAY_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_SCK_HALF:   sck_half_q   <= cfg_wdata[15:0];
				CFG_SEL_SETUP:  sel_setup_q  <= cfg_wdata[15:0];
				CFG_MODE_DELAY: mode_delay_q <= cfg_wdata[23:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			cnt_q       <= '0;
			bit_q       <= '0;
			byte_q      <= '0;
			shift_q     <= '0;
			read_q      <= '0;
			flash_q     <= 1'b0;
			ss_q        <= 1'b1;
			sck_q       <= 1'b1;
			mosi_q      <= 1'b0;
			ej_q        <= 1'b1;
			xx_q        <= 1'b1;
			cmd_op_q    <= OP_READ;
			cmd_reg_q   <= '0;
			cmd_count_q <= '0;
			cmd_wdata_q <= '0;
		end else if (advance) begin
			phase_q     <= n_phase;
			cnt_q       <= n_cnt;
			bit_q       <= n_bit;
			byte_q      <= n_byte;
			shift_q     <= n_shift;
			read_q      <= n_read;
			flash_q     <= n_flash;
			ss_q        <= n_ss;
			sck_q       <= n_sck;
			mosi_q      <= n_mosi;
			ej_q        <= n_ej;
			xx_q        <= n_xx;
			cmd_op_q    <= n_cmd_op;
			cmd_reg_q   <= n_cmd_reg;
			cmd_count_q <= n_cmd_count;
			cmd_wdata_q <= n_cmd_wdata;
		end
	end

	lsbsq_queue #(
		.WIDTH ($bits(rsp_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_out_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (advance),
		.wr_data (nxt_rsp),
		.full    (out_full),
		.pop     (pop),
		.rd_data (rd_vec),
		.empty   (empty)
	);

	assign rsp = rsp_t'(rd_vec);

	// select stays low for the whole bit phase of a transfer
	a_sel_low_in_bits: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_LOW || phase_q == PH_HIGH) |-> !ss_q)
		else $error("select high during a bit phase");

	// byte index never passes the longest read
	a_byte_range: assert property (@(posedge clk) disable iff (!arst_n)
		byte_q <= 3'd6)
		else $error("byte index out of range");

	// sequencer state only moves on an engine step
	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(phase_q) && $stable(flash_q) && $stable(read_q))
		else $error("state moved without a step");

	// sck rises only from the low phase
	a_sck_rise: assert property (@(posedge clk) disable iff (!arst_n)
		advance && phase_q == PH_LOW && cnt_q == '0 |=> sck_q && phase_q == PH_HIGH)
		else $error("sck did not rise at end of low phase");

endmodule

FILE: dv/lsb_spi_register_access_sequencer_unit_tb.sv
// ----------------------------------------------------------------------------
// lsb_spi_register_access_sequencer_unit_tb
// Self-checking bench for the lsb-first spi register sequencer. Every pushed
// tick word is run through a cycle-level predictor of the pin sequencer and
// the popped result words are compared field by field, in order. A short
// directed table is followed by randomized command traffic over several
// timing setups, with idling on both queue sides and a long result stall.
// ----------------------------------------------------------------------------
module lsb_spi_register_access_sequencer_unit_tb import lsbsq_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STALL_LIMIT = 5000;
	localparam int HOLD_CYCLES = 400;
	localparam logic [2:0] OP_RSVD_6 = 3'd6;
	localparam logic [2:0] OP_RSVD_7 = 3'd7;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

	localparam rsp_t PINS_RESET = '{select_n: 1'b1, sck: 1'b1, mosi: 1'b0,
		eject_line: 1'b1, xx_line: 1'b1, busy_res: 1'b0, done_res: 1'b0,
		rdata: 32'd0, flash_mode: 1'b0};
	localparam rsp_t PINS_DONE = '{select_n: 1'b1, sck: 1'b1, mosi: 1'b0,
		eject_line: 1'b1, xx_line: 1'b1, busy_res: 1'b0, done_res: 1'b1,
		rdata: 32'd0, flash_mode: 1'b0};
	localparam rsp_t PINS_READ_SEL = '{select_n: 1'b0, sck: 1'b1, mosi: 1'b0,
		eject_line: 1'b1, xx_line: 1'b1, busy_res: 1'b1, done_res: 1'b0,
		rdata: 32'd0, flash_mode: 1'b0};

	typedef enum logic [3:0] {
		ST_IDLE, ST_SELECT, ST_CLK_LOW, ST_CLK_HIGH, ST_SHUT_WAIT,
		ST_ENTER_1, ST_ENTER_2, ST_ENTER_3, ST_LEAVE_WAIT
	} link_state_t;

	typedef enum {ROW_TICK, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t             kind;
		req_t                  word;
		bit                    exact;
		rsp_t                  want;
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] val;
	} dir_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic                  push = 1'b0;
	logic                  full;
	req_t                  req = '0;
	logic                  empty;
	logic                  pop = 1'b0;
	rsp_t                  rsp;

	// predictor copy of config and sequencer state
	logic [15:0] sck_half_cfg = SCK_HALF_RST;
	logic [15:0] setup_cfg = SEL_SETUP_RST;
	logic [23:0] mode_delay_cfg = MODE_DELAY_RST;

	link_state_t link_state = ST_IDLE;
	logic [23:0] wait_left = '0;
	int          bit_no = 0;
	int          byte_no = 0;
	logic [7:0]  out_byte = '0;
	logic [31:0] rd_acc = '0;
	logic        flash_on = 1'b0;
	logic        p_ss = 1'b1, p_sck = 1'b1, p_mosi = 1'b0, p_ej = 1'b1, p_xx = 1'b1;
	logic [2:0]  c_op = '0;
	logic [5:0]  c_reg = '0;
	int          c_count = 0;
	logic [31:0] c_wdata = '0;

	rsp_t pin_words_due[$];
	int   errors = 0;
	int   stall_cycles = 0;
	int   send_idle_pct = 0;
	int   recv_idle_pct = 0;
	bit   allow_serial = 1'b1;
	bit   allow_mode = 1'b1;
	int   holds_asked = 0;
	int   holds_served = 0;
	int   hold_left = 0;

	lsb_spi_register_access_sequencer_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.push      (push),
		.full      (full),
		.req       (req),
		.empty     (empty),
		.pop       (pop),
		.rsp       (rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [23:0] half_hold();
		return (sck_half_cfg == 16'd0) ? 24'd0 : 24'(sck_half_cfg - 16'd1);
	endfunction

	function automatic bit fetching();
		return c_op == OP_READ && byte_no >= 2;
	endfunction

	function automatic int total_bytes();
		return (c_op == OP_READ) ? 2 + c_count : 5;
	endfunction

	function automatic logic [7:0] byte_to_send(int idx);
		if (idx == 0)
			return {c_reg, (c_op == OP_READ) ? 2'b01 : 2'b10};
		if (c_op == OP_READ)
			return (idx == 1) ? DUMMY_BYTE : 8'h00;
		return c_wdata[((idx - 1) % 4) * 8 +: 8];
	endfunction

	function automatic void begin_bit();
		p_mosi = fetching() ? 1'b0 : out_byte[bit_no];
		p_sck = 1'b0;
		wait_left = half_hold();
		link_state = ST_CLK_LOW;
	endfunction

	// one tick of the sequencer, returns the pin word after it
	function automatic rsp_t advance_tick(req_t w);
		rsp_t r;
		logic done;
		done = 1'b0;
		if (link_state == ST_IDLE) begin
			if (w.start_req && w.op <= OP_SHUTDOWN) begin
				c_op = w.op;
				c_reg = w.reg_req;
				c_wdata = w.wdata;
				c_count = (w.byte_count == 3'd0) ? 1 :
					((w.byte_count > 3'd4) ? 4 : int'(w.byte_count));
				case (w.op)
					OP_READ, OP_WRITE: begin
						if (w.op == OP_READ)
							rd_acc = '0;
						p_ss = 1'b0;
						wait_left = 24'(setup_cfg);
						link_state = ST_SELECT;
					end
					OP_ENTER_FLASH: begin
						p_xx = 1'b0;
						wait_left = mode_delay_cfg;
						link_state = ST_ENTER_1;
					end
					OP_SHUTDOWN: begin
						p_ss = 1'b1;
						p_xx = 1'b0;
						p_ej = 1'b0;
						wait_left = mode_delay_cfg;
						link_state = ST_SHUT_WAIT;
					end
					default: begin
						if (flash_on || w.op == OP_FORCE_LEAVE) begin
							p_ss = 1'b1;
							p_ej = 1'b0;
							wait_left = mode_delay_cfg;
							link_state = ST_LEAVE_WAIT;
						end else begin
							done = 1'b1;
						end
					end
				endcase
			end
		end else if (wait_left != 24'd0) begin
			wait_left--;
		end else begin
			case (link_state)
				ST_SELECT: begin
					byte_no = 0;
					bit_no = 0;
					out_byte = byte_to_send(0);
					begin_bit();
				end
				ST_CLK_LOW: begin
					p_sck = 1'b1;
					wait_left = half_hold();
					link_state = ST_CLK_HIGH;
				end
				ST_CLK_HIGH: begin
					// miso is taken on the tick that drops sck
					if (fetching())
						rd_acc[((byte_no - 2) % 4) * 8 + bit_no] =
							rd_acc[((byte_no - 2) % 4) * 8 + bit_no] | w.miso;
					p_sck = 1'b0;
					if (bit_no < 7) begin
						bit_no++;
						begin_bit();
					end else begin
						byte_no++;
						if (byte_no < total_bytes()) begin
							bit_no = 0;
							out_byte = byte_to_send(byte_no);
							begin_bit();
						end else begin
							p_ss = 1'b1;
							done = 1'b1;
							link_state = ST_IDLE;
						end
					end
				end
				ST_SHUT_WAIT: begin
					p_ej = 1'b1;
					done = 1'b1;
					link_state = ST_IDLE;
				end
				ST_ENTER_1: begin
					p_ss = 1'b0;
					p_ej = 1'b0;
					wait_left = mode_delay_cfg;
					link_state = ST_ENTER_2;
				end
				ST_ENTER_2: begin
					p_xx = 1'b1;
					p_ej = 1'b1;
					wait_left = mode_delay_cfg;
					link_state = ST_ENTER_3;
				end
				ST_ENTER_3: begin
					p_ss = 1'b0;
					flash_on = 1'b1;
					done = 1'b1;
					link_state = ST_IDLE;
				end
				ST_LEAVE_WAIT: begin
					p_xx = 1'b0;
					p_ej = 1'b1;
					flash_on = 1'b0;
					done = 1'b1;
					link_state = ST_IDLE;
				end
				default: begin
					link_state = ST_IDLE;
				end
			endcase
		end
		r.select_n = p_ss;
		r.sck = p_sck;
		r.mosi = p_mosi;
		r.eject_line = p_ej;
		r.xx_line = p_xx;
		r.busy_res = (link_state != ST_IDLE);
		r.done_res = done;
		r.rdata = rd_acc;
		r.flash_mode = flash_on;
		return r;
	endfunction

	// ops whose run time stays short under the current timing setup
	function automatic bit op_cheap(logic [2:0] op);
		case (op)
			OP_READ, OP_WRITE: return allow_serial;
			OP_ENTER_FLASH, OP_FORCE_LEAVE, OP_SHUTDOWN: return allow_mode;
			OP_LEAVE_FLASH: return allow_mode || !flash_on;
			default: return 1'b1;
		endcase
	endfunction

	function automatic req_t next_word();
		req_t w;
		int pick;
		w.reg_req = 6'($urandom_range(0, 63));
		w.byte_count = 3'($urandom_range(0, 7));
		w.wdata = $urandom();
		w.miso = 1'($urandom_range(0, 1));
		if (link_state != ST_IDLE) begin
			// requests while busy are dropped by the block
			w.start_req = ($urandom_range(0, 4) == 0);
			w.op = 3'($urandom_range(0, 7));
		end else begin
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				w.op = 3'($urandom_range(0, 5));
				w.start_req = op_cheap(w.op);
			end else if (pick < 85) begin
				w.op = 3'($urandom_range(0, 7));
				w.start_req = 1'b0;
			end else begin
				w.op = $urandom_range(0, 1) ? OP_RSVD_6 : OP_RSVD_7;
				w.start_req = 1'b1;
			end
		end
		return w;
	endfunction

	task automatic flag_error(string msg);
		$display("ERROR %0t ns: %s", $time, msg);
		errors++;
	endtask

	task automatic cmp_field(string name, logic [31:0] got, logic [31:0] want);
		if (got !== want)
			flag_error($sformatf("%s got %0h want %0h", name, got, want));
	endtask

	task automatic check_word(rsp_t got);
		rsp_t want;
		if (pin_words_due.size() == 0) begin
			flag_error("result word with nothing expected");
			return;
		end
		want = pin_words_due.pop_front();
		cmp_field("select_n", 32'(got.select_n), 32'(want.select_n));
		cmp_field("sck", 32'(got.sck), 32'(want.sck));
		cmp_field("mosi", 32'(got.mosi), 32'(want.mosi));
		cmp_field("eject_line", 32'(got.eject_line), 32'(want.eject_line));
		cmp_field("xx_line", 32'(got.xx_line), 32'(want.xx_line));
		cmp_field("busy_res", 32'(got.busy_res), 32'(want.busy_res));
		cmp_field("done_res", 32'(got.done_res), 32'(want.done_res));
		cmp_field("rdata", got.rdata, want.rdata);
		cmp_field("flash_mode", 32'(got.flash_mode), 32'(want.flash_mode));
	endtask

	task automatic send_word(req_t w, bit exact, rsp_t want);
		rsp_t pred;
		int gap;
		req <= w;
		push <= 1'b1;
		do @(posedge clk); while (full);
		pred = advance_tick(w);
		pin_words_due.push_back(exact ? want : pred);
		gap = 0;
		while ($urandom_range(0, 99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic finish_command();
		while (link_state != ST_IDLE)
			send_word(next_word(), 1'b0, PINS_RESET);
	endtask

	task automatic drain_link();
		push <= 1'b0;
		while (pin_words_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
		case (idx)
			CFG_SCK_HALF: sck_half_cfg = val[15:0];
			CFG_SEL_SETUP: setup_cfg = val[15:0];
			CFG_MODE_DELAY: mode_delay_cfg = val;
			default: ;
		endcase
	endtask

	task automatic run_phase(logic [15:0] sck_h, logic [15:0] setup, logic [23:0] delay,
			bit serial_ok, bit mode_ok, int s_idle, int r_idle, int count, bit squeeze);
		finish_command();
		drain_link();
		cfg_write(CFG_SCK_HALF, {8'h00, sck_h});
		cfg_write(CFG_SEL_SETUP, {8'h00, setup});
		cfg_write(CFG_MODE_DELAY, delay);
		allow_serial = serial_ok;
		allow_mode = mode_ok;
		send_idle_pct = s_idle;
		recv_idle_pct = r_idle;
		for (int i = 0; i < count; i++) begin
			if (squeeze && i == 60)
				holds_asked++;
			send_word(next_word(), 1'b0, PINS_RESET);
		end
	endtask

	function automatic dir_row_t cmd_row(logic go, logic [2:0] op, logic [5:0] rg,
			logic [2:0] cnt, logic [31:0] wd, logic mi, bit exact, rsp_t want);
		dir_row_t r;
		r.kind = ROW_TICK;
		r.word = '{start_req: go, op: op, reg_req: rg, byte_count: cnt, wdata: wd, miso: mi};
		r.exact = exact;
		r.want = want;
		r.idx = '0;
		r.val = '0;
		return r;
	endfunction

	function automatic dir_row_t cfg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		dir_row_t r;
		r.kind = ROW_CFG;
		r.word = '0;
		r.exact = 1'b0;
		r.want = PINS_RESET;
		r.idx = idx;
		r.val = val;
		return r;
	endfunction

	// result side: check, stall at random, and serve long hold-offs
	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty)
				check_word(rsp);
			if (holds_served != holds_asked) begin
				holds_served++;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0)
				hold_left--;
			pop <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty))
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("FAIL lsb_spi_register_access_sequencer_unit");
			$finish;
		end
	end

	initial begin
		dir_row_t plan[$];
		plan.push_back(cmd_row(1'b0, OP_READ, 6'd0, 3'd0, 32'h0, 1'b0, 1'b1, PINS_RESET));
		// fields set but no start request
		plan.push_back(cmd_row(1'b0, OP_READ, 6'h3F, 3'd7, 32'hFFFF_FFFF, 1'b1, 1'b1,
			PINS_RESET));
		// leave outside flash mode only pulses done
		plan.push_back(cmd_row(1'b1, OP_LEAVE_FLASH, 6'd0, 3'd0, 32'h0, 1'b0, 1'b1,
			PINS_DONE));
		plan.push_back(cmd_row(1'b1, OP_RSVD_6, 6'd0, 3'd0, 32'h0, 1'b0, 1'b1, PINS_RESET));
		plan.push_back(cmd_row(1'b1, OP_RSVD_7, 6'h3F, 3'd7, 32'hFFFF_FFFF, 1'b1, 1'b1,
			PINS_RESET));
		plan.push_back(cmd_row(1'b1, OP_READ, 6'h3F, 3'd1, 32'h0, 1'b0, 1'b1,
			PINS_READ_SEL));
		plan.push_back(cmd_row(1'b1, OP_READ, 6'd0, 3'd0, 32'h0, 1'b1, 1'b0, PINS_RESET));
		plan.push_back(cmd_row(1'b1, OP_READ, 6'd42, 3'd2, 32'h0, 1'b0, 1'b0, PINS_RESET));
		plan.push_back(cmd_row(1'b1, OP_READ, 6'd21, 3'd3, 32'h0, 1'b1, 1'b0, PINS_RESET));
		plan.push_back(cmd_row(1'b1, OP_READ, 6'd5, 3'd4, 32'h0, 1'b0, 1'b0, PINS_RESET));
		plan.push_back(cmd_row(1'b1, OP_READ, 6'h3F, 3'd7, 32'h0, 1'b1, 1'b0, PINS_RESET));
		plan.push_back(cmd_row(1'b1, OP_WRITE, 6'h3F, 3'd0, 32'hFFFF_FFFF, 1'b0, 1'b0,
			PINS_RESET));
		plan.push_back(cmd_row(1'b1, OP_WRITE, 6'd0, 3'd0, 32'h0, 1'b0, 1'b0, PINS_RESET));
		plan.push_back(cmd_row(1'b1, OP_WRITE, 6'd17, 3'd4, 32'h1234_ABCD, 1'b1, 1'b0,
			PINS_RESET));
		// zero half period runs as one tick
		plan.push_back(cfg_row(CFG_SCK_HALF, 24'd0));
		plan.push_back(cfg_row(CFG_SEL_SETUP, 24'd0));
		plan.push_back(cfg_row(CFG_MODE_DELAY, 24'd3));
		plan.push_back(cmd_row(1'b1, OP_READ, 6'd9, 3'd4, 32'h0, 1'b0, 1'b0, PINS_RESET));
		plan.push_back(cmd_row(1'b1, OP_ENTER_FLASH, 6'd0, 3'd0, 32'h0, 1'b0, 1'b0,
			PINS_RESET));
		plan.push_back(cmd_row(1'b1, OP_LEAVE_FLASH, 6'd0, 3'd0, 32'h0, 1'b0, 1'b0,
			PINS_RESET));
		plan.push_back(cmd_row(1'b1, OP_FORCE_LEAVE, 6'd0, 3'd0, 32'h0, 1'b0, 1'b0,
			PINS_RESET));
		plan.push_back(cmd_row(1'b1, OP_ENTER_FLASH, 6'd0, 3'd0, 32'h0, 1'b0, 1'b0,
			PINS_RESET));
		plan.push_back(cmd_row(1'b1, OP_SHUTDOWN, 6'd0, 3'd0, 32'h0, 1'b0, 1'b0,
			PINS_RESET));
		// unused register index must be dropped
		plan.push_back(cfg_row(CFG_UNUSED, 24'hFF_FFFF));
		plan.push_back(cmd_row(1'b1, OP_WRITE, 6'd33, 3'd0, 32'h5A5A_A5A5, 1'b0, 1'b0,
			PINS_RESET));

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_idle_pct = 6;
		recv_idle_pct = 50;

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_CFG) begin
				finish_command();
				drain_link();
				cfg_write(plan[i].idx, plan[i].val);
			end else begin
				send_word(plan[i].word, plan[i].exact, plan[i].want);
				finish_command();
			end
		end

		run_phase(16'd1, 16'd0, 24'd0, 1'b1, 1'b1, 6, 50, 250, 1'b0);
		run_phase(16'd3, 16'd5, 24'd9, 1'b1, 1'b1, 50, 6, 250, 1'b0);
		// widest serial timing: only pin sequences stay short here
		run_phase(16'hFFFF, 16'hFFFF, 24'd4, 1'b0, 1'b1, 0, 0, 100, 1'b0);
		// widest mode delay: only serial commands stay short here
		run_phase(16'd1, 16'd1, 24'hFF_FFFF, 1'b1, 1'b0, 0, 0, 150, 1'b1);
		run_phase(16'd2, 16'd0, 24'd1, 1'b1, 1'b1, 0, 0, 100, 1'b0);
		finish_command();
		drain_link();

		if (errors == 0)
			$display("PASS lsb_spi_register_access_sequencer_unit");
		else
			$display("FAIL lsb_spi_register_access_sequencer_unit");
		$finish;
	end

endmodule
